// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the sorted record table unit.
// Every check is sampled on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must be true in every cycle.
`define ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the antecedent is true, the consequent must be true in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent is true, the consequent must be true in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/srt_pkg.sv =====
`timescale 1ns / 1ps

package srt_pkg;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned PHONE_W = 64;
   localparam int unsigned BIRTH_W = 27;
   localparam int unsigned MONTH_W = 7;

   // Operation codes of the input item.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_LIST   = 2'd2;
   localparam logic [1:0] ACT_FIND   = 2'd3;

   // Status codes of a result.
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_RECORD   = 3'd4;
   localparam logic [2:0] ST_NOMATCH  = 3'd5;

   // The month is (birth mod 10000) / 100, which equals (birth / 100) mod 100.
   localparam int unsigned MOD_DIV = 10000;
   localparam int unsigned MON_DIV = 100;

   // A division by 100 is a shift right by two and a multiplication by the reciprocal
   // of 25; the result is exact for every dividend below 2^30.
   localparam int unsigned RECIP_SHIFT = 30;
   localparam logic [25:0] RECIP_25    = 26'd42949673;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   name_key;
      logic [PHONE_W-1:0] phone_digits;
      logic [BIRTH_W-1:0] birth_date;
      logic [MONTH_W-1:0] month_query;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [KEY_W-1:0]   out_name;
      logic [PHONE_W-1:0] out_phone;
      logic [BIRTH_W-1:0] out_birth;
      logic               last;
   } rsp_type;

   // One table entry; the birth month is kept next to the date for the find scan.
   typedef struct packed {
      logic [MONTH_W-1:0] month;
      logic [BIRTH_W-1:0] birth;
      logic [PHONE_W-1:0] phone;
      logic [KEY_W-1:0]   name;
   } rec_type;

endpackage

// ===== hw/rtl/srt_record_mem.sv =====
`timescale 1ns / 1ps

module srt_record_mem #(
   parameter int unsigned DEPTH  = 64,
   parameter int unsigned ADDR_W = 6
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  srt_pkg::rec_type   wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output srt_pkg::rec_type   rd_data
);

   srt_pkg::rec_type store_mem [DEPTH];
   srt_pkg::rec_type rd_data_ff;

   // Read data holds its value until the next read is issued.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/srt_month_unit.sv =====
`timescale 1ns / 1ps

module srt_month_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [srt_pkg::BIRTH_W-1:0]     birth,
   output logic                            done,
   output logic [srt_pkg::MONTH_W-1:0]     month
);

   // birth / 100 fits in 21 bits and birth / 10000 in 15 bits.
   localparam int unsigned HI_W = srt_pkg::BIRTH_W - 2;
   localparam int unsigned R_W  = $bits(srt_pkg::RECIP_25);
   localparam int unsigned Q1_W = 21;
   localparam int unsigned Q2_W = 15;
   localparam int unsigned P1_W = HI_W + R_W;
   localparam int unsigned P2_W = Q1_W - 2 + R_W;

   logic                          stage1_ff;
   logic                          stage2_ff;
   logic                          done_ff;
   logic [Q1_W-1:0]               quo1_ff, quo1_in;
   logic [Q1_W-1:0]               quo1_dly_ff;
   logic [Q2_W-1:0]               quo2_ff, quo2_in;
   logic [srt_pkg::MONTH_W-1:0]   month_ff, month_in;

   logic [P1_W-1:0]               prod1;
   logic [P2_W-1:0]               prod2;
   logic [Q1_W-1:0]               diff;

   // Three stages: birth / 100, then that quotient / 100, then the remainder of the
   // second division, which is the month.
   always_comb begin
      prod1    = P1_W'(birth[srt_pkg::BIRTH_W-1:2]) * P1_W'(srt_pkg::RECIP_25);
      quo1_in  = prod1[srt_pkg::RECIP_SHIFT +: Q1_W];
      prod2    = P2_W'(quo1_ff[Q1_W-1:2]) * P2_W'(srt_pkg::RECIP_25);
      quo2_in  = prod2[srt_pkg::RECIP_SHIFT +: Q2_W];
      diff     = quo1_dly_ff - Q1_W'(quo2_ff) * Q1_W'(srt_pkg::MON_DIV);
      month_in = diff[srt_pkg::MONTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         stage2_ff <= stage1_ff;
         done_ff   <= stage2_ff;
      end
      if (start) begin
         quo1_ff <= quo1_in;
      end
      if (stage1_ff) begin
         quo2_ff     <= quo2_in;
         quo1_dly_ff <= quo1_ff;
      end
      if (stage2_ff) begin
         month_ff <= month_in;
      end
   end

   assign done  = done_ff;
   assign month = month_ff;

endmodule

// ===== hw/rtl/sorted_record_table_unit.sv =====
// Sequence: insert is accepted, waits for the month pipeline, moves entries up one at a time,
//    then writes the new record and responds; delete, list and find scan the entries in turn.
// Throughput: one operation at a time; a new item is taken only while the sequencer is idle.
//    List and find also pause whenever the response register is stalled.
// Reset: synchronous, active high; clears the entry count and control, not the memory.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_record_table_unit #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srt_pkg::rsp_type rsp_data
);

   localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);

   // Sequencer states. SCAN serves delete, list and find; INS moves entries up for insert.
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_MONTH  = 6'b000010,
      ST_INS    = 6'b000100,
      ST_PUT    = 6'b001000,
      ST_SCAN   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   srt_pkg::req_type       req_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;
   logic                   more_ff, more_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   hit_ff, hit_in;
   logic                   hold_vld_ff, hold_vld_in;
   srt_pkg::rec_type       hold_ff, hold_in;
   logic [2:0]             fin_ff, fin_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   srt_pkg::rsp_type       rsp_data_ff;

   logic                   accept;
   logic                   out_free;
   logic                   adv;
   logic                   emit;
   srt_pkg::rsp_type       emit_data;
   logic [CNT_W-1:0]       cnt_m1;
   logic [ADDR_W-1:0]      last_idx;
   logic                   is_last;
   logic                   rec_match;
   logic                   hit_now;
   srt_pkg::rec_type       new_rec;

   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   srt_pkg::rec_type       rd_data;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   srt_pkg::rec_type       wr_data;

   logic                   div_start;
   logic                   div_done;
   logic [srt_pkg::MONTH_W-1:0] div_month;

   // The record memory holds the sorted table; all shifting goes through its one
   // read port and one write port, one entry per cycle.
   srt_record_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The month unit finds the birth month of a record before it is inserted. It starts
   // in the accepting cycle, so it takes the date straight from the incoming transfer.
   srt_month_unit u_month (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .birth  (req_data.birth_date),
      .done   (div_done),
      .month  (div_month)
   );

   // A new item is taken only when the sequencer is idle. A result still waiting in the
   // response register does not block acceptance.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // The response register can be loaded when it is empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Insert and delete emit nothing until their end, so only list and find must wait
   // for room in the response register while scanning.
   assign adv = out_free || (req_ff.action == srt_pkg::ACT_INSERT) ||
                (req_ff.action == srt_pkg::ACT_DELETE);

   assign cnt_m1   = count_ff - CNT_W'(1);
   assign last_idx = cnt_m1[ADDR_W-1:0];
   assign is_last  = (rd_idx_ff == last_idx);

   assign rec_match = (req_ff.action == srt_pkg::ACT_LIST) ||
                      (rd_data.month == req_ff.month_query);
   assign hit_now   = hit_ff || (rd_data.name == req_ff.name_key);

   always_comb begin
      new_rec.month = div_month;
      new_rec.birth = req_ff.birth_date;
      new_rec.phone = req_ff.phone_digits;
      new_rec.name  = req_ff.name_key;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      more_in     = more_ff;
      hit_in      = hit_ff;
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      fin_in      = fin_ff;
      rd_en       = 1'b0;
      rd_addr     = ptr_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = new_rec;
      emit        = 1'b0;
      emit_data   = '0;
      div_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_vld_in = 1'b0;
               hit_in      = 1'b0;
               ptr_in      = '0;
               more_in     = 1'b1;
               unique case (req_data.action) inside
                  srt_pkg::ACT_INSERT: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        fin_in   = srt_pkg::ST_FULL;
                        state_in = ST_FINISH;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_MONTH;
                     end
                  end
                  srt_pkg::ACT_DELETE, srt_pkg::ACT_LIST: begin
                     fin_in   = srt_pkg::ST_EMPTY;
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                     fin_in   = srt_pkg::ST_NOMATCH;
                     state_in = (count_ff == '0) ? ST_FINISH : ST_SCAN;
                  end
               endcase
            end
         end

         ST_MONTH: begin
            // Wait for the month; an empty table takes the new record at entry zero.
            if (div_done) begin
               if (count_ff == '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  count_in = count_ff + CNT_W'(1);
                  fin_in   = srt_pkg::ST_DONE;
                  state_in = ST_FINISH;
               end else begin
                  ptr_in   = last_idx;
                  more_in  = 1'b1;
                  state_in = ST_INS;
               end
            end
         end

         ST_INS: begin
            // Walk down from the top entry. Entries not below the new key move up by one;
            // the first smaller entry marks where the new record goes.
            if (more_ff) begin
               rd_en = 1'b1;
               if (ptr_ff == '0) begin
                  more_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff - ADDR_W'(1);
               end
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff + ADDR_W'(1);
               if (rd_data.name >= req_ff.name_key) begin
                  wr_data = rd_data;
                  if (rd_idx_ff == '0) begin
                     state_in = ST_PUT;
                  end
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  fin_in   = srt_pkg::ST_DONE;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_PUT: begin
            // Every entry moved up, so no stored key is below the new one.
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = count_ff + CNT_W'(1);
            fin_in   = srt_pkg::ST_DONE;
            state_in = ST_FINISH;
         end

         ST_SCAN: begin
            if (adv) begin
               if (more_ff) begin
                  rd_en = 1'b1;
                  if (ptr_ff == last_idx) begin
                     more_in = 1'b0;
                  end else begin
                     ptr_in = ptr_ff + ADDR_W'(1);
                  end
               end
               if (rd_vld_ff) begin
                  if (req_ff.action == srt_pkg::ACT_DELETE) begin
                     // After the first exact match every later entry moves down by one.
                     if (hit_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = rd_idx_ff - ADDR_W'(1);
                        wr_data = rd_data;
                     end
                     hit_in = hit_now;
                     if (is_last) begin
                        if (hit_now) begin
                           count_in = cnt_m1;
                           fin_in   = srt_pkg::ST_DONE;
                        end else begin
                           fin_in   = srt_pkg::ST_NOTFOUND;
                        end
                        state_in = ST_FINISH;
                     end
                  end else begin
                     // One matching record is held back so that the final one can carry
                     // the last flag.
                     if (rec_match) begin
                        if (hold_vld_ff) begin
                           emit                = 1'b1;
                           emit_data.status    = srt_pkg::ST_RECORD;
                           emit_data.out_name  = hold_ff.name;
                           emit_data.out_phone = hold_ff.phone;
                           emit_data.out_birth = hold_ff.birth;
                           emit_data.last      = 1'b0;
                        end
                        hold_in     = rd_data;
                        hold_vld_in = 1'b1;
                     end
                     if (is_last) begin
                        fin_in   = srt_pkg::ST_NOMATCH;
                        state_in = ST_FINISH;
                     end
                  end
               end
            end
         end

         ST_FINISH: begin
            // The closing transfer: the held record, or the status when none is held.
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (hold_vld_ff) begin
                  emit_data.status    = srt_pkg::ST_RECORD;
                  emit_data.out_name  = hold_ff.name;
                  emit_data.out_phone = hold_ff.phone;
                  emit_data.out_birth = hold_ff.birth;
               end else begin
                  emit_data.status = fin_ff;
               end
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read data tracking: a read issued while scanning is consumed in the next advancing
   // cycle; outside the scan states nothing is in flight.
   always_comb begin
      rd_idx_in = rd_en ? rd_addr : rd_idx_ff;
      if ((state_ff == ST_INS) || (state_ff == ST_SCAN)) begin
         rd_vld_in = adv ? rd_en : rd_vld_ff;
      end else begin
         rd_vld_in = 1'b0;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         more_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         more_ff      <= more_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
      ptr_ff    <= ptr_in;
      rd_idx_ff <= rd_idx_in;
      hold_ff   <= hold_in;
      fin_ff    <= fin_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The table never holds more entries than it has room for.
   `ASSERT_HOLDS(a_count_range, count_ff <= CNT_W'(TABLE_DEPTH), "entry count above depth")
   // A result is never loaded over one that is still stalled.
   `ASSERT_IMPLIES(a_emit_room, emit, out_free, "result overwrites a stalled transfer")
   // The memory is written only while an insert or delete is moving entries or placing a record.
   `ASSERT_IMPLIES(a_write_state, wr_en, (state_ff != ST_IDLE) && (state_ff != ST_FINISH), "stray memory write")
   // Placing a record at entry zero always grows the table by one.
   `ASSERT_NEXT(a_put_count, state_ff == ST_PUT, count_ff == $past(count_ff) + CNT_W'(1), "insert count slip")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned DEPTH = 64;

   // Clock, reset and the two channels of the block.
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid;
   logic             req_stall;
   srt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   srt_pkg::rsp_type rsp_data;

   // Shadow copy of the record table, kept in ascending key order.
   logic [srt_pkg::KEY_W-1:0]   rec_key   [DEPTH];
   logic [srt_pkg::PHONE_W-1:0] rec_phone [DEPTH];
   logic [srt_pkg::BIRTH_W-1:0] rec_birth [DEPTH];
   int unsigned                 rec_count;

   // Results the block still owes us, oldest first.
   srt_pkg::rsp_type awaited_rsp [$];

   // A small pool of names, so that deletes hit and equal keys pile up.
   logic [srt_pkg::KEY_W-1:0] name_pool [12];

   int unsigned fail_count;
   int unsigned ops_sent;
   int unsigned rsp_checked;
   int unsigned peak_count;

   // When set, neither side inserts idle cycles.
   bit no_idle;

   sorted_record_table_unit #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs; this is far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Birth month as the table sees it: (date mod 10000) / 100 of the raw 27-bit value.
   function automatic int unsigned birth_month(input logic [srt_pkg::BIRTH_W-1:0] birth);
      int unsigned value;
      value = birth;
      return (value % srt_pkg::MOD_DIV) / srt_pkg::MON_DIV;
   endfunction

   // Mostly well-formed YYYYMMDD dates; now and then any 27-bit value.
   function automatic logic [srt_pkg::BIRTH_W-1:0] random_birth();
      int unsigned date;
      if ($urandom_range(0, 3) == 0) begin
         return srt_pkg::BIRTH_W'($urandom);
      end
      date = $urandom_range(1900, 2099) * 10000 + $urandom_range(1, 12) * 100
             + $urandom_range(1, 31);
      return srt_pkg::BIRTH_W'(date);
   endfunction

   // Deletes mostly aim at a stored name; otherwise names come from the pool,
   // the full 64-bit range, or the two ends of the key space.
   function automatic logic [srt_pkg::KEY_W-1:0] pick_key(input bit for_delete);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (for_delete && rec_count > 0 && roll < 7) begin
         return rec_key[$urandom_range(0, rec_count - 1)];
      end
      if (roll < 6) begin
         return name_pool[$urandom_range(0, 11)];
      end
      if (roll < 9) begin
         return rand64();
      end
      return ($urandom_range(0, 1) == 0) ? '0 : '1;
   endfunction

   function automatic srt_pkg::req_type make_op(input logic [1:0] action,
                                                input logic [srt_pkg::KEY_W-1:0] key,
                                                input logic [srt_pkg::PHONE_W-1:0] phone,
                                                input logic [srt_pkg::BIRTH_W-1:0] birth,
                                                input logic [srt_pkg::MONTH_W-1:0] month);
      srt_pkg::req_type op;
      op.action       = action;
      op.name_key     = key;
      op.phone_digits = phone;
      op.birth_date   = birth;
      op.month_query  = month;
      return op;
   endfunction

   // Status-only results carry zero record fields and always close the operation.
   task automatic await_status(input logic [2:0] status);
      srt_pkg::rsp_type r;
      r        = '0;
      r.status = status;
      r.last   = 1'b1;
      awaited_rsp.push_back(r);
   endtask

   task automatic await_record(input int unsigned idx, input bit is_last);
      srt_pkg::rsp_type r;
      r.status    = srt_pkg::ST_RECORD;
      r.out_name  = rec_key[idx];
      r.out_phone = rec_phone[idx];
      r.out_birth = rec_birth[idx];
      r.last      = is_last;
      awaited_rsp.push_back(r);
   endtask

   // Applies one accepted operation to the shadow table and queues the results
   // that it must produce.
   task automatic model_table_op(input srt_pkg::req_type op);
      int unsigned i;
      int unsigned pos;
      int unsigned hits;
      int unsigned seen;
      bit          hit;
      case (op.action)
         srt_pkg::ACT_INSERT: begin
            if (rec_count >= DEPTH) begin
               await_status(srt_pkg::ST_FULL);
            end else begin
               // The new record goes after every strictly smaller key, so it
               // lands in front of any records with an equal key.
               pos = 0;
               for (i = 0; i < rec_count; i++) begin
                  if (rec_key[i] < op.name_key) pos++;
               end
               for (i = rec_count; i > pos; i--) begin
                  rec_key[i]   = rec_key[i-1];
                  rec_phone[i] = rec_phone[i-1];
                  rec_birth[i] = rec_birth[i-1];
               end
               rec_key[pos]   = op.name_key;
               rec_phone[pos] = op.phone_digits;
               rec_birth[pos] = op.birth_date;
               rec_count++;
               if (rec_count > peak_count) peak_count = rec_count;
               await_status(srt_pkg::ST_DONE);
            end
         end
         srt_pkg::ACT_DELETE: begin
            if (rec_count == 0) begin
               await_status(srt_pkg::ST_EMPTY);
            end else begin
               hit = 1'b0;
               pos = 0;
               for (i = 0; i < rec_count && !hit; i++) begin
                  if (rec_key[i] == op.name_key) begin
                     hit = 1'b1;
                     pos = i;
                  end
               end
               if (!hit) begin
                  await_status(srt_pkg::ST_NOTFOUND);
               end else begin
                  for (i = pos + 1; i < rec_count; i++) begin
                     rec_key[i-1]   = rec_key[i];
                     rec_phone[i-1] = rec_phone[i];
                     rec_birth[i-1] = rec_birth[i];
                  end
                  rec_count--;
                  await_status(srt_pkg::ST_DONE);
               end
            end
         end
         srt_pkg::ACT_LIST: begin
            if (rec_count == 0) begin
               await_status(srt_pkg::ST_EMPTY);
            end else begin
               for (i = 0; i < rec_count; i++) await_record(i, i == rec_count - 1);
            end
         end
         default: begin
            // Find by month: count the hits first so the final one gets last.
            hits = 0;
            for (i = 0; i < rec_count; i++) begin
               if (birth_month(rec_birth[i]) == op.month_query) hits++;
            end
            if (hits == 0) begin
               await_status(srt_pkg::ST_NOMATCH);
            end else begin
               seen = 0;
               for (i = 0; i < rec_count; i++) begin
                  if (birth_month(rec_birth[i]) == op.month_query) begin
                     seen++;
                     await_record(i, seen == hits);
                  end
               end
            end
         end
      endcase
   endtask

   // Sends one operation. Inputs change on the falling edge; the transfer is
   // seen on the rising edge where valid is high and stall is low. Valid stays
   // high after a transfer, so a back-to-back item only swaps the payload.
   task automatic send_op(input srt_pkg::req_type op);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = op;
      do @(posedge clock); while (req_stall !== 1'b0);
      ops_sent++;
      model_table_op(op);
   endtask

   // Lowers valid and holds the sender back until every owed result has come.
   task automatic wait_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic check_rsp(input srt_pkg::rsp_type got);
      srt_pkg::rsp_type want;
      if (awaited_rsp.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result, status %0d name %h last %b",
                  $time, got.status, got.out_name, got.last);
         return;
      end
      want = awaited_rsp.pop_front();
      rsp_checked++;
      if (got.status !== want.status) begin
         fail_count++;
         $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.out_name !== want.out_name) begin
         fail_count++;
         $display("%0t: out_name expected %h actual %h", $time, want.out_name, got.out_name);
      end
      if (got.out_phone !== want.out_phone) begin
         fail_count++;
         $display("%0t: out_phone expected %h actual %h", $time, want.out_phone,
                  got.out_phone);
      end
      if (got.out_birth !== want.out_birth) begin
         fail_count++;
         $display("%0t: out_birth expected %0d actual %0d", $time, want.out_birth,
                  got.out_birth);
      end
      if (got.last !== want.last) begin
         fail_count++;
         $display("%0t: last expected %b actual %b", $time, want.last, got.last);
      end
   endtask

   // Result side. For every result it draws a number of stall cycles, then
   // drops stall and takes the next transfer.
   initial begin : rsp_sink
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 4);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_rsp(rsp_data);
      end
   end

   // Delete, list and find on a table that has never held anything.
   task automatic test_empty_table();
      send_op(make_op(srt_pkg::ACT_DELETE, rand64(), rand64(), random_birth(), 7'd1));
      send_op(make_op(srt_pkg::ACT_LIST, rand64(), rand64(), random_birth(), 7'd1));
      send_op(make_op(srt_pkg::ACT_FIND, rand64(), rand64(), random_birth(), 7'd1));
   endtask

   // Field extremes, equal keys, out-of-range dates and months, and the found and
   // not-found delete outcomes.
   task automatic test_directed_ops();
      logic [srt_pkg::KEY_W-1:0] alice;
      logic [srt_pkg::KEY_W-1:0] bob;
      logic [srt_pkg::KEY_W-1:0] carol;
      alice = 64'h414C_4943_4500_0000;
      bob   = 64'h424F_4200_0000_0000;
      carol = 64'h4341_524F_4C00_0000;
      send_op(make_op(srt_pkg::ACT_INSERT, '0, '0, '0, '0));
      // The largest 27-bit date lies above the decimal range; its month reads as 77.
      send_op(make_op(srt_pkg::ACT_INSERT, '1, '1, '1, '1));
      send_op(make_op(srt_pkg::ACT_INSERT, alice, 64'h0123_4567_8901_2345,
                      27'd19900215, '0));
      // Same name again: it must be placed in front of the first one.
      send_op(make_op(srt_pkg::ACT_INSERT, alice, 64'h5555_0000_1111_9999,
                      27'd20011231, '0));
      send_op(make_op(srt_pkg::ACT_INSERT, bob, 64'h9876_5432_1098_7654,
                      27'd99999999, '0));
      send_op(make_op(srt_pkg::ACT_LIST, '0, '0, '0, '0));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd2));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd12));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd0));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd77));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd99));
      send_op(make_op(srt_pkg::ACT_FIND, '1, '1, '1, 7'd127));
      send_op(make_op(srt_pkg::ACT_FIND, '0, '0, '0, 7'd13));
      send_op(make_op(srt_pkg::ACT_DELETE, alice, '0, '0, '0));
      send_op(make_op(srt_pkg::ACT_LIST, '0, '0, '0, '0));
      send_op(make_op(srt_pkg::ACT_DELETE, carol, '1, '1, '1));
      send_op(make_op(srt_pkg::ACT_DELETE, '0, '0, '0, '0));
      send_op(make_op(srt_pkg::ACT_DELETE, '1, '0, '0, '0));
      send_op(make_op(srt_pkg::ACT_LIST, '0, '0, '0, '0));
   endtask

   // Random operations whose mix follows the table fill, so the count wanders
   // between empty and well filled. Unused fields carry random noise.
   task automatic test_random_mix(input int unsigned n_ops);
      int unsigned                 k;
      int unsigned                 roll;
      logic [1:0]                  act;
      logic [srt_pkg::MONTH_W-1:0] month;
      for (k = 0; k < n_ops; k++) begin
         roll = $urandom_range(0, 99);
         if (rec_count < 8) begin
            act = (roll < 60) ? srt_pkg::ACT_INSERT : (roll < 80) ? srt_pkg::ACT_DELETE :
                  (roll < 88) ? srt_pkg::ACT_LIST : srt_pkg::ACT_FIND;
         end else if (rec_count > 40) begin
            act = (roll < 30) ? srt_pkg::ACT_INSERT : (roll < 85) ? srt_pkg::ACT_DELETE :
                  (roll < 90) ? srt_pkg::ACT_LIST : srt_pkg::ACT_FIND;
         end else begin
            act = (roll < 45) ? srt_pkg::ACT_INSERT : (roll < 80) ? srt_pkg::ACT_DELETE :
                  (roll < 86) ? srt_pkg::ACT_LIST : srt_pkg::ACT_FIND;
         end
         month = ($urandom_range(0, 4) == 0) ? srt_pkg::MONTH_W'($urandom) :
                 srt_pkg::MONTH_W'($urandom_range(1, 12));
         send_op(make_op(act, pick_key(act == srt_pkg::ACT_DELETE), rand64(),
                         random_birth(), month));
      end
   endtask

   // The sender holds off until the block has delivered everything, then
   // sends single operations into an otherwise quiet block.
   task automatic test_pause_until_drained();
      wait_drain();
      send_op(make_op(srt_pkg::ACT_LIST, rand64(), rand64(), random_birth(), '0));
      wait_drain();
      send_op(make_op(srt_pkg::ACT_INSERT, pick_key(1'b0), rand64(), random_birth(), '0));
      wait_drain();
      send_op(make_op(srt_pkg::ACT_FIND, rand64(), rand64(), random_birth(), 7'd6));
      wait_drain();
   endtask

   // A stretch with no idle cycles on either side.
   task automatic test_quiet_burst(input int unsigned n_ops);
      no_idle = 1'b1;
      test_random_mix(n_ops);
      no_idle = 1'b0;
   endtask

   // Fills the table, overflows it once, reads all of it back, then thins it out.
   task automatic test_fill_to_full();
      int unsigned k;
      while (rec_count < DEPTH) begin
         send_op(make_op(srt_pkg::ACT_INSERT, pick_key(1'b0), rand64(), random_birth(), '0));
      end
      send_op(make_op(srt_pkg::ACT_INSERT, rand64(), rand64(), random_birth(), '0));
      send_op(make_op(srt_pkg::ACT_LIST, rand64(), rand64(), random_birth(), '0));
      send_op(make_op(srt_pkg::ACT_FIND, rand64(), rand64(), random_birth(),
                      srt_pkg::MONTH_W'($urandom_range(1, 12))));
      for (k = 0; k < 24; k++) begin
         send_op(make_op(srt_pkg::ACT_DELETE, pick_key(1'b1), rand64(), random_birth(), '0));
      end
   endtask

   initial begin : stimulus
      int unsigned i;
      req_valid   = 1'b0;
      req_data    = '0;
      rec_count   = 0;
      fail_count  = 0;
      ops_sent    = 0;
      rsp_checked = 0;
      peak_count  = 0;
      no_idle     = 1'b0;
      for (i = 0; i < 12; i++) name_pool[i] = rand64();

      // Synchronous reset, released on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_directed_ops();
      test_random_mix(140);
      test_pause_until_drained();
      test_quiet_burst(30);
      test_fill_to_full();
      test_random_mix(110);

      // Let the last results drain, then give the block time to show anything extra.
      wait_drain();
      repeat (100) @(posedge clock);

      $display("Run covered %0d operations and %0d checked results;", ops_sent, rsp_checked);
      $display("the table peaked at %0d of %0d entries, with empty, full, equal-key, %s",
               peak_count, DEPTH, "missing-name and no-match cases under random stalls.");
      if (fail_count == 0 && awaited_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
